// ----- hdl/spwm_pkg.sv -----
// Package: types and constants shared by the shadowed PWM generator.
`timescale 1ns / 1ps

package spwm_pkg;

  localparam int unsigned CNT_W = 32;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_ENABLE  = 2'd2,
    OP_DISABLE = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] period_value;
    logic [31:0] pulse_value;
  } in_req_t;

  typedef struct packed {
    logic pin_level;
    logic period_start;
    logic counting;
  } out_res_t;

  typedef struct packed {
    logic             enabled_flag;
    logic             counter_running;
    logic             in_rest_phase;
    logic [CNT_W-1:0] pending_period;
    logic [CNT_W-1:0] pending_pulse;
    logic [CNT_W-1:0] active_period;
    logic [CNT_W-1:0] active_pulse;
    logic [CNT_W-1:0] ticks_left;
    logic             pin_register;
  } pwm_state_t;

endpackage

// ----- hdl/spwm_step.sv -----
// Step logic: next PWM state and result for one request.
`timescale 1ns / 1ps

module spwm_step (
  input  spwm_pkg::in_req_t    req,
  input  spwm_pkg::pwm_state_t cur,
  input  logic                 invert,
  output spwm_pkg::pwm_state_t nxt,
  output spwm_pkg::out_res_t   res
);

  function automatic spwm_pkg::pwm_state_t latch_period(
    input spwm_pkg::pwm_state_t s,
    input logic                 inv
  );
    spwm_pkg::pwm_state_t r;
    r               = s;
    r.in_rest_phase = 1'b0;
    r.active_period = s.pending_period;
    r.active_pulse  = s.pending_pulse;
    if (s.pending_period == s.pending_pulse) begin
      r.pin_register    = (s.pending_period != '0) ? ~inv : inv;
      r.ticks_left      = '0;
      r.counter_running = 1'b0;
    end else if (s.pending_pulse == '0) begin
      r.pin_register    = inv;
      r.ticks_left      = s.pending_period;
      r.in_rest_phase   = 1'b1;
      r.counter_running = 1'b1;
    end else begin
      r.pin_register    = ~inv;
      r.ticks_left      = s.pending_pulse;
      r.counter_running = 1'b1;
    end
    return r;
  endfunction

  logic [spwm_pkg::CNT_W-1:0] per;
  logic [spwm_pkg::CNT_W-1:0] pul;
  logic [spwm_pkg::CNT_W-1:0] pul_clamped;
  logic                       start;
  spwm_pkg::pwm_state_t       tmp;

  assign per         = req.period_value[spwm_pkg::CNT_W-1:0];
  assign pul         = req.pulse_value[spwm_pkg::CNT_W-1:0];
  assign pul_clamped = (pul > per) ? per : pul;

  always_comb begin
    nxt   = cur;
    start = 1'b0;
    tmp   = cur;
    unique case (req.opcode)
      spwm_pkg::OP_TICK: begin
        if (cur.enabled_flag && cur.counter_running) begin
          if (cur.ticks_left > spwm_pkg::CNT_W'(1)) begin
            nxt.ticks_left = cur.ticks_left - spwm_pkg::CNT_W'(1);
          end else if (cur.in_rest_phase) begin
            nxt   = latch_period(cur, invert);
            start = 1'b1;
          end else begin
            nxt.pin_register  = invert;
            nxt.ticks_left    = cur.active_period - cur.active_pulse;
            nxt.in_rest_phase = 1'b1;
          end
        end
      end
      spwm_pkg::OP_SET: begin
        tmp.pending_period = per;
        tmp.pending_pulse  = pul_clamped;
        nxt                = tmp;
        if (cur.enabled_flag && !cur.counter_running) begin
          nxt   = latch_period(tmp, invert);
          start = 1'b1;
        end
      end
      spwm_pkg::OP_ENABLE: begin
        if (!cur.enabled_flag) begin
          tmp.enabled_flag = 1'b1;
          nxt              = latch_period(tmp, invert);
          start            = 1'b1;
        end
      end
      spwm_pkg::OP_DISABLE: begin
        nxt.enabled_flag    = 1'b0;
        nxt.counter_running = 1'b0;
        nxt.in_rest_phase   = 1'b0;
        nxt.ticks_left      = '0;
        nxt.pin_register    = invert;
      end
      default: begin
        nxt = cur;
      end
    endcase
    res.pin_level    = nxt.pin_register;
    res.period_start = start;
    res.counting     = nxt.counter_running;
  end

endmodule

// ----- hdl/shadowed_pwm_generator_unit.sv -----
// Top level: request register, PWM state, result register and config port.
// A request waits in the request register until the result register is free.
// Throughput: one request per cycle unless the output stalls; the step logic, a few
// 32-bit compares and subtracts on the tick counter and shadows, sits between them.
// Reset: synchronous active-low rst_n clears all PWM state, the invert
// register and both valid flags; the block is ready as soon as rst_n is released.
`timescale 1ns / 1ps

module shadowed_pwm_generator_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  spwm_pkg::in_req_t    in_req,
  output logic                 out_valid,
  input  logic                 out_stall,
  output spwm_pkg::out_res_t   out_res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  logic                 req_valid_r;
  spwm_pkg::in_req_t    req_r;
  spwm_pkg::pwm_state_t st_r;
  spwm_pkg::pwm_state_t st_nxt;
  spwm_pkg::out_res_t   res_nxt;
  spwm_pkg::out_res_t   res_r;
  logic                 res_valid_r;
  logic                 invert_r;
  logic                 out_free;
  logic                 advance;

  assign out_free  = !res_valid_r || !out_stall;
  assign advance   = req_valid_r && out_free;
  assign in_stall  = req_valid_r && !out_free;
  assign cfg_ready = 1'b1;
  assign out_valid = res_valid_r;
  assign out_res   = res_r;

  spwm_step u_step (
    .req    (req_r),
    .cur    (st_r),
    .invert (invert_r),
    .nxt    (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
      invert_r    <= 1'b0;
      st_r        <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        invert_r <= cfg_data;
      end
      if (in_valid && !in_stall) begin
        req_valid_r <= 1'b1;
      end else if (advance) begin
        req_valid_r <= 1'b0;
      end
      if (advance) begin
        res_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_req;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  a_run_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.counter_running |-> st_r.enabled_flag)
    else $error("counter running while disabled");

  a_run_ticks_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.counter_running |-> (st_r.ticks_left != '0))
    else $error("counter running with zero ticks left");

  a_pulse_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.active_pulse <= st_r.active_period) &&
    (st_r.pending_pulse <= st_r.pending_period))
    else $error("pulse exceeds period");

  a_result_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> res_valid_r)
    else $error("advanced request produced no result");

endmodule
